// File: rtl/serial_bus_atn_command_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial bus ATN command decoder
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BUS_ATN_COMMAND_DECODER_TOP_ASSERT_SVH
`define SERIAL_BUS_ATN_COMMAND_DECODER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SBACD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBACD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbacd_pkg.sv
// ----------------------------------------------------------------------------
// sbacd_pkg
// Types and codes shared by the serial bus ATN command decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbacd_pkg;

  // event kinds carried in tuser
  localparam logic [1:0] ACT_ATN_ON  = 2'd0;
  localparam logic [1:0] ACT_ATN_OFF = 2'd1;
  localparam logic [1:0] ACT_BYTE    = 2'd2;

  // command groups, top three bits of a bus byte
  localparam logic [2:0] GRP_LISTEN = 3'd1;
  localparam logic [2:0] GRP_TALK   = 3'd2;
  localparam logic [2:0] GRP_REOPEN = 3'd3;
  localparam logic [2:0] GRP_CLOSE  = 3'd7;

  localparam logic [4:0] DEV_ALL = 5'd31;

  // reported phase codes
  localparam logic [1:0] PH_CODE_IDLE    = 2'd0;
  localparam logic [1:0] PH_CODE_ACTIVE  = 2'd1;
  localparam logic [1:0] PH_CODE_RELEASE = 2'd2;

  localparam int unsigned MaskWidth = 31;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_ACTIVE  = 3'b010,
    PH_RELEASE = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic       pend_valid;
    logic [2:0] pend_primary;
    logic [4:0] pend_device;
    logic [3:0] pend_secondary;
    logic [3:0] pend_channel;
    logic       pend_has_sec;
    logic       fast;
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       atn_level;
    logic       receive_error;
    logic       fast_mode_seen;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [2:0] primary;
    logic [4:0] device;
    logic [3:0] secondary;
    logic [3:0] channel;
    logic       has_sec;
    logic [1:0] bus_phase;
    logic       release_lines;
    logic       attention_ack;
    logic       turnaround;
    logic       fast_protocol;
  } result_t;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_IDLE:    code = PH_CODE_IDLE;
      PH_ACTIVE:  code = PH_CODE_ACTIVE;
      PH_RELEASE: code = PH_CODE_RELEASE;
      default:    code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sbacd_decode.sv
// ----------------------------------------------------------------------------
// sbacd_decode
// Next-state and result logic for one bus event.
// ----------------------------------------------------------------------------
`default_nettype none

module sbacd_decode
  import sbacd_pkg::*;
(
  input  state_t                 state_i,
  input  logic [MaskWidth-1:0]   mask_i,
  input  item_t                  item_i,
  output state_t                 state_o,
  output result_t                result_o
);

  logic [2:0]         grp;
  logic [4:0]         dev;
  logic [MaskWidth:0] mask_ext;
  logic               enabled;
  logic               byte_ok;
  logic               do_hand;
  state_t             nxt;

  assign grp      = item_i.data_byte[7:5];
  assign dev      = item_i.data_byte[4:0];
  assign mask_ext = {1'b0, mask_i};
  assign enabled  = (dev != DEV_ALL) && mask_ext[dev];
  assign byte_ok  = (state_i.phase == PH_ACTIVE) && !item_i.receive_error &&
                    item_i.atn_level;

  always_comb begin
    nxt      = state_i;
    result_o = '0;
    do_hand  = 1'b0;

    unique case (item_i.action)
      ACT_ATN_ON: begin
        result_o.attention_ack = 1'b1;
        nxt.phase = PH_ACTIVE;
        nxt.fast  = 1'b0;
      end
      ACT_ATN_OFF: begin
        if (state_i.phase == PH_RELEASE) begin
          result_o.release_lines = 1'b1;
          nxt.phase = PH_IDLE;
        end else begin
          if (item_i.fast_mode_seen) begin
            nxt.fast = 1'b1;
          end
          do_hand = 1'b1;
        end
      end
      ACT_BYTE: begin
        if (byte_ok) begin
          case (grp)
            GRP_LISTEN, GRP_TALK: begin
              if (!enabled) begin
                if (dev == DEV_ALL) begin
                  nxt.phase = PH_RELEASE;
                end else begin
                  nxt.phase = PH_IDLE;
                  result_o.release_lines = 1'b1;
                end
                do_hand = 1'b1;
              end else begin
                nxt.pend_valid     = 1'b1;
                nxt.pend_primary   = grp;
                nxt.pend_device    = dev;
                nxt.pend_secondary = '0;
                nxt.pend_channel   = '0;
                nxt.pend_has_sec   = 1'b0;
              end
            end
            GRP_REOPEN: begin
              if (state_i.pend_valid) begin
                nxt.pend_secondary = item_i.data_byte[7:4];
                nxt.pend_channel   = item_i.data_byte[3:0];
                nxt.pend_has_sec   = 1'b1;
                if (state_i.pend_primary == GRP_TALK) begin
                  nxt.phase = PH_IDLE;
                  result_o.turnaround = 1'b1;
                  do_hand = 1'b1;
                end
              end
            end
            GRP_CLOSE: begin
              if (state_i.pend_valid) begin
                nxt.pend_secondary = item_i.data_byte[7:4];
                nxt.pend_channel   = item_i.data_byte[3:0];
                nxt.pend_has_sec   = 1'b1;
                do_hand = (dev == 5'd0);
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // hand on the pending command, with any secondary taken this item
    if (do_hand) begin
      if (nxt.pend_valid) begin
        result_o.emit      = 1'b1;
        result_o.primary   = nxt.pend_primary;
        result_o.device    = nxt.pend_device;
        result_o.secondary = nxt.pend_secondary;
        result_o.channel   = nxt.pend_channel;
        result_o.has_sec   = nxt.pend_has_sec;
      end
      nxt.pend_valid = 1'b0;
    end

    result_o.bus_phase     = phase_code(nxt.phase);
    result_o.fast_protocol = nxt.fast;
    state_o = nxt;
  end

endmodule

`default_nettype wire

// File: rtl/serial_bus_atn_command_decoder_top.sv
// ----------------------------------------------------------------------------
// serial_bus_atn_command_decoder_top
// Device-side decoder for attention-phase commands on a serial bus.
// Datapath: input register, then decode into the result register.
// Throughput: one item per cycle while the result register is free or being drained.
// Reset (rst_ni low, async): phase idle, no pending command, standard serial,
// device mask cleared, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_bus_atn_command_decoder_top_assert.svh"

module serial_bus_atn_command_decoder_top
  import sbacd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MaskWidth-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] data_byte, [8] atn_level, [9] receive_error, [10] fast_mode_seen
  input  logic [15:0]          s_axis_tdata,
  // [1:0] action
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] emit_command, [3:1] cmd_primary, [8:4] cmd_device, [12:9] cmd_secondary,
  // [16:13] cmd_channel, [17] has_secondary, [19:18] bus_phase,
  // [20] release_lines, [21] attention_ack, [22] turnaround, [23] fast_protocol
  output logic [23:0]          m_axis_tdata
);

  logic [MaskWidth-1:0] mask_q;
  logic                 in_valid_q;
  item_t                in_q;
  logic                 out_valid_q;
  result_t              out_q;
  state_t               state_q;
  state_t               state_d;
  result_t              res_d;
  logic                 adv;
  logic                 step;

  // result register free or being drained
  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = adv && in_valid_q;
  assign s_axis_tready = adv || !in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.action         <= s_axis_tuser;
      in_q.data_byte      <= s_axis_tdata[7:0];
      in_q.atn_level      <= s_axis_tdata[8];
      in_q.receive_error  <= s_axis_tdata[9];
      in_q.fast_mode_seen <= s_axis_tdata[10];
    end
  end

  sbacd_decode u_decode (
    .state_i  (state_q),
    .mask_i   (mask_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, default: '0};
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.fast_protocol, out_q.turnaround, out_q.attention_ack,
                          out_q.release_lines, out_q.bus_phase, out_q.has_sec,
                          out_q.channel, out_q.secondary, out_q.device,
                          out_q.primary, out_q.emit};

  `SBACD_ASSERT_SAME(a_emit_needs_pending, step && res_d.emit, state_q.pend_valid,
                     "command emitted without a pending command")
  `SBACD_ASSERT_NEXT(a_emit_clears_pending, step && res_d.emit, !state_q.pend_valid,
                     "pending command kept after hand-on")
  `SBACD_ASSERT_SAME(a_turn_goes_idle, m_axis_tvalid && out_q.turnaround,
                     out_q.bus_phase == PH_CODE_IDLE && out_q.emit,
                     "turnaround without idle phase and emitted command")
  `SBACD_ASSERT_SAME(a_ack_excludes_release, m_axis_tvalid && out_q.attention_ack,
                     !out_q.release_lines && out_q.bus_phase == PH_CODE_ACTIVE,
                     "attention ack together with release or wrong phase")

endmodule

`default_nettype wire
